// ===== rtl/core/mspt_pkg.sv =====
// shared types and constants for the motor speed pid controller with tachometer
package mspt_pkg;

    typedef enum logic [1:0] {
        CMD_PULSE     = 2'd0,
        CMD_TICK      = 2'd1,
        CMD_WIN_END   = 2'd2,
        CMD_CYCLE_END = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_SETPOINT   = 3'd0,
        REG_PROP_GAIN  = 3'd1,
        REG_INTEG_GAIN = 3'd2,
        REG_DERIV_GAIN = 3'd3,
        REG_PPR        = 3'd4,
        REG_GEAR_RATIO = 3'd5,
        REG_RATE_MODE  = 3'd6,
        REG_TOT_HOLD   = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_MUL_K,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic load;
    } mac_ctrl_t;

    localparam logic [1:0] RATE_STOPPED = 2'd0;
    localparam logic [1:0] RATE_DUTY    = 2'd1;

    localparam int unsigned RPM_W       = 13;
    localparam int unsigned DIV_N_W     = 23;
    localparam int unsigned DIV_D_W     = 32;
    localparam int unsigned MAC_A_W     = 34;
    localparam int unsigned MAC_B_W     = 16;
    localparam int unsigned MAC_ACC_W   = 48;
    localparam int unsigned MATCH_SHIFT = 24;

    localparam logic [DIV_N_W-1:0]   SPEED_DIVIDEND = 23'd6000000;
    localparam logic [RPM_W-1:0]     RPM_MAX        = 13'd8191;
    localparam logic [9:0]           PWM_MAX        = 10'd599;
    localparam logic signed [14:0]   INTEG_LIMIT    = 15'sd5300;
    localparam logic [7:0]           STALL_TICKS    = 8'd200;
    localparam logic [7:0]           SETTLE_TICKS   = 8'd10;
    localparam logic [7:0]           SETTLE_RESET   = 8'd100;
    // 10965/2^16 ~ 1/5.977, offset 636092*256 ~ 9.706 * 2^24
    localparam logic [MAC_B_W-1:0]   K_SCALE        = 16'd10965;
    localparam logic [MAC_ACC_W-1:0] K_OFFSET       = 48'd162839552;

endpackage

// ===== rtl/core/mspt_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module mspt_div #(
    parameter int unsigned N_W = 23,
    parameter int unsigned D_W = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic [N_W-1:0] quotient,
    output logic           done
);

    localparam int unsigned CNT_W = $clog2(N_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [N_W-1:0]   quot_reg;
    logic [D_W-1:0]   rem_reg;

    logic [D_W:0]     rem_shift;
    logic [D_W:0]     rem_sub;
    logic             fits;

    // dividend bits shift out the top while quotient bits shift in below
    assign rem_shift = {rem_reg, quot_reg[N_W-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor};
    assign fits      = rem_shift >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(N_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (cnt_reg != '0)
        begin
            quot_reg <= {quot_reg[N_W-2:0], fits};
            rem_reg  <= fits ? rem_sub[D_W-1:0] : rem_shift[D_W-1:0];
        end
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/core/mspt_mac.sv =====
// bit-serial multiply-accumulate, signed multiplicand by unsigned multiplier
module mspt_mac #(
    parameter int unsigned A_W   = 34,
    parameter int unsigned B_W   = 16,
    parameter int unsigned ACC_W = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mspt_pkg::mac_ctrl_t ctrl,
    input  logic [A_W-1:0]      mcand,
    input  logic [B_W-1:0]      mplr,
    input  logic [ACC_W-1:0]    preload,
    output logic [ACC_W-1:0]    acc,
    output logic                done
);

    localparam int unsigned CNT_W = $clog2(B_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] mcand_reg;
    logic [B_W-1:0]   mplr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (ctrl.start)
            begin
                cnt_reg <= CNT_W'(B_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // multiplier bits leave lsb first, multiplicand doubles each step
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            if (ctrl.load)
            begin
                acc_reg <= preload;
            end
            mcand_reg <= {{(ACC_W - A_W){mcand[A_W-1]}}, mcand};
            mplr_reg  <= mplr;
        end
        else if (cnt_reg != '0)
        begin
            if (mplr_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg <= {mcand_reg[ACC_W-2:0], 1'b0};
            mplr_reg  <= {1'b0, mplr_reg[B_W-1:1]};
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/motor_speed_pid_with_tacho.sv =====
// top level: tachometer, totalizer, duty gate and serial pid speed loop
//
// Input channel (in_valid / in_stall) carries one command per beat: encoder
// pulse with its capture time, control tick with pump_on, on-window end or
// cycle end. Pulse and window beats start no work and give no
// result. A control tick gives one result beat on the output channel
// (out_valid / out_stall) with the pwm match, speed, power, alarm and total.
// A tick holds in_stall high while it runs: when the speed is measured,
// the bit-serial 6000000/period divider, then four passes through the
// bit-serial multiply-accumulate unit (three pid products and the pwm
// scaling). Without a measurement the divide is skipped.
// The result sits in an output register; new beats are taken while it
// waits. If the receiver still stalls a previous result when a tick
// finishes, the tick waits for it before loading and releasing the input.
// Configuration writes (cfg_valid / cfg_ready, ready always high) must go
// in between ticks; the block does not enforce this. Reset loads the
// register defaults and the idle state; the block is ready right after reset.
module motor_speed_pid_with_tacho (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] capture_time,
    input  logic        pump_on,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [9:0]  pwm_match,
    output logic [12:0] motor_rpm,
    output logic        motor_power,
    output logic        stall_alarm,
    output logic [31:0] total_turns,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int unsigned ACC_W = mspt_pkg::MAC_ACC_W;
    localparam int unsigned Q_W   = ACC_W - 1 - mspt_pkg::MATCH_SHIFT;

    // configuration
    logic [12:0] setpoint_reg;
    logic [15:0] prop_gain_reg;
    logic [15:0] integ_gain_reg;
    logic [15:0] deriv_gain_reg;
    logic [7:0]  ppr_reg;
    logic [7:0]  gear_ratio_reg;
    logic [1:0]  rate_mode_reg;
    logic        tot_hold_reg;

    // tachometer and loop state
    logic [7:0]         pulse_cnt_reg;
    logic [15:0]        turn_cnt_reg;
    logic [15:0]        turn_seen_reg;
    logic [7:0]         gear_cnt_reg;
    logic [31:0]        total_reg;
    logic [31:0]        last_cap_reg;
    logic [31:0]        period_reg;
    logic [7:0]         settle_reg;
    logic [7:0]         stall_cnt_reg;
    logic signed [13:0] integ_sum_reg;
    logic signed [13:0] prev_err_reg;
    logic               cycle_gate_reg;
    logic               motor_run_reg;

    // per-tick working values
    logic               pump_reg;
    logic               alarm_reg;
    logic [12:0]        rpm_reg;
    logic signed [14:0] d_reg;

    // output register
    logic        out_valid_reg;
    logic [9:0]  pwm_out_reg;
    logic [12:0] rpm_out_reg;
    logic        power_out_reg;
    logic        alarm_out_reg;
    logic [31:0] total_out_reg;

    mspt_pkg::state_t state_reg;
    mspt_pkg::state_t state_next;

    logic in_accept;
    logic is_tick;
    logic cfg_write;

    logic       count_wrap;
    logic [7:0] gear_inc;
    logic       gear_hit;
    logic       cap_later;

    logic       turn_changed;
    logic [7:0] settle_eff;
    logic       measure;
    logic       stall_fire;

    logic                          div_start;
    logic                          div_done;
    logic [mspt_pkg::DIV_N_W-1:0]  div_quot;
    logic [12:0]                   rpm_sat;

    logic signed [13:0] err;
    logic signed [14:0] integ_raw;
    logic signed [13:0] integ_clamped;
    logic signed [14:0] diff;

    mspt_pkg::mac_ctrl_t          mac_ctrl;
    logic [mspt_pkg::MAC_A_W-1:0] mac_a;
    logic [mspt_pkg::MAC_B_W-1:0] mac_b;
    logic [ACC_W-1:0]             mac_preload;
    logic [ACC_W-1:0]             mac_acc;
    logic                         mac_done;

    logic [Q_W-1:0] match_q;
    logic [9:0]     match;
    logic           drive;
    logic           out_free;
    logic           out_load;

    assign in_accept = in_valid && !in_stall;
    assign is_tick   = in_accept && (mspt_pkg::cmd_t'(command) == mspt_pkg::CMD_TICK);
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // encoder pulse
    assign count_wrap = (pulse_cnt_reg == 8'd0);
    assign gear_inc   = gear_cnt_reg + 8'd1;
    assign gear_hit   = (gear_inc == gear_ratio_reg);
    assign cap_later  = (capture_time > last_cap_reg);

    // tick bookkeeping, known at accept
    assign turn_changed = (turn_cnt_reg != turn_seen_reg);
    assign settle_eff   = turn_changed ? mspt_pkg::SETTLE_TICKS : settle_reg;
    assign measure      = (settle_eff != 8'd0);
    assign stall_fire   = (stall_cnt_reg > mspt_pkg::STALL_TICKS) || (stall_cnt_reg == 8'hFF);

    mspt_div #(
        .N_W (mspt_pkg::DIV_N_W),
        .D_W (mspt_pkg::DIV_D_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mspt_pkg::SPEED_DIVIDEND),
        .divisor  (period_reg),
        .quotient (div_quot),
        .done     (div_done)
    );

    assign rpm_sat = (|div_quot[mspt_pkg::DIV_N_W-1:mspt_pkg::RPM_W])
                   ? mspt_pkg::RPM_MAX : div_quot[mspt_pkg::RPM_W-1:0];

    // error, clamped integral and derivative
    assign err       = $signed({1'b0, setpoint_reg}) - $signed({1'b0, rpm_reg});
    assign integ_raw = $signed({integ_sum_reg[13], integ_sum_reg}) + $signed({err[13], err});
    assign diff      = $signed({err[13], err}) - $signed({prev_err_reg[13], prev_err_reg});

    always_comb
    begin
        if (integ_raw > mspt_pkg::INTEG_LIMIT)
        begin
            integ_clamped = mspt_pkg::INTEG_LIMIT[13:0];
        end
        else if (integ_raw < -mspt_pkg::INTEG_LIMIT)
        begin
            integ_clamped = 14'(-mspt_pkg::INTEG_LIMIT);
        end
        else
        begin
            integ_clamped = integ_raw[13:0];
        end
    end

    mspt_mac #(
        .A_W   (mspt_pkg::MAC_A_W),
        .B_W   (mspt_pkg::MAC_B_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .mcand   (mac_a),
        .mplr    (mac_b),
        .preload (mac_preload),
        .acc     (mac_acc),
        .done    (mac_done)
    );

    // n >> 24 clamped to the pwm range, negative n gives zero
    assign match_q = mac_acc[ACC_W-2:mspt_pkg::MATCH_SHIFT];
    assign match   = mac_acc[ACC_W-1] ? 10'd0
                   : (match_q > Q_W'(mspt_pkg::PWM_MAX)) ? mspt_pkg::PWM_MAX
                   : match_q[9:0];
    assign drive   = pump_reg && ((rate_mode_reg == mspt_pkg::RATE_DUTY) ? cycle_gate_reg
                                  : (rate_mode_reg != mspt_pkg::RATE_STOPPED));

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mspt_pkg::ST_IDLE:
            begin
                if (is_tick)
                begin
                    state_next = measure ? mspt_pkg::ST_DIV : mspt_pkg::ST_PREP;
                end
            end
            mspt_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = mspt_pkg::ST_PREP;
                end
            end
            mspt_pkg::ST_PREP:
            begin
                state_next = mspt_pkg::ST_MUL_P;
            end
            mspt_pkg::ST_MUL_P:
            begin
                if (mac_done)
                begin
                    state_next = mspt_pkg::ST_MUL_I;
                end
            end
            mspt_pkg::ST_MUL_I:
            begin
                if (mac_done)
                begin
                    state_next = mspt_pkg::ST_MUL_D;
                end
            end
            mspt_pkg::ST_MUL_D:
            begin
                if (mac_done)
                begin
                    state_next = mspt_pkg::ST_MUL_K;
                end
            end
            mspt_pkg::ST_MUL_K:
            begin
                if (mac_done)
                begin
                    state_next = mspt_pkg::ST_DONE;
                end
            end
            mspt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = mspt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mspt_pkg::ST_IDLE;
            end
        endcase
    end

    // fsm outputs: each mac pass is launched as the previous one reports done
    always_comb
    begin
        in_stall       = (state_reg != mspt_pkg::ST_IDLE);
        div_start      = is_tick && measure;
        out_load       = 1'b0;
        mac_ctrl.start = 1'b0;
        mac_ctrl.load  = 1'b0;
        mac_a          = '0;
        mac_b          = '0;
        mac_preload    = '0;
        case (state_reg)
            mspt_pkg::ST_PREP:
            begin
                mac_ctrl.start = 1'b1;
                mac_ctrl.load  = 1'b1;
                mac_preload    = {{(ACC_W - 21){1'b0}}, setpoint_reg, 8'd0};
                mac_a          = {{(mspt_pkg::MAC_A_W - 14){err[13]}}, err};
                mac_b          = prop_gain_reg;
            end
            mspt_pkg::ST_MUL_P:
            begin
                mac_ctrl.start = mac_done;
                mac_a          = {{(mspt_pkg::MAC_A_W - 14){integ_sum_reg[13]}}, integ_sum_reg};
                mac_b          = integ_gain_reg;
            end
            mspt_pkg::ST_MUL_I:
            begin
                mac_ctrl.start = mac_done;
                mac_a          = {{(mspt_pkg::MAC_A_W - 15){d_reg[14]}}, d_reg};
                mac_b          = deriv_gain_reg;
            end
            mspt_pkg::ST_MUL_D:
            begin
                mac_ctrl.start = mac_done;
                mac_ctrl.load  = 1'b1;
                mac_preload    = mspt_pkg::K_OFFSET;
                mac_a          = mac_acc[mspt_pkg::MAC_A_W-1:0];
                mac_b          = mspt_pkg::K_SCALE;
            end
            mspt_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mspt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // configuration and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg   <= '0;
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            ppr_reg        <= 8'd1;
            gear_ratio_reg <= 8'd1;
            rate_mode_reg  <= mspt_pkg::RATE_STOPPED;
            tot_hold_reg   <= 1'b0;
            pulse_cnt_reg  <= '0;
            turn_cnt_reg   <= '0;
            turn_seen_reg  <= '0;
            gear_cnt_reg   <= '0;
            total_reg      <= '0;
            last_cap_reg   <= '0;
            period_reg     <= 32'd1;
            settle_reg     <= mspt_pkg::SETTLE_RESET;
            stall_cnt_reg  <= '0;
            integ_sum_reg  <= '0;
            prev_err_reg   <= '0;
            cycle_gate_reg <= 1'b1;
            motor_run_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                case (mspt_pkg::cmd_t'(command))
                    mspt_pkg::CMD_PULSE:
                    begin
                        if (count_wrap)
                        begin
                            pulse_cnt_reg <= ppr_reg - 8'd1;
                            turn_cnt_reg  <= turn_cnt_reg + 16'd1;
                            if (gear_hit)
                            begin
                                gear_cnt_reg <= '0;
                                if (!tot_hold_reg)
                                begin
                                    total_reg <= total_reg + 32'd1;
                                end
                            end
                            else
                            begin
                                gear_cnt_reg <= gear_inc;
                            end
                            // a capture that is not later keeps the old period
                            if (cap_later)
                            begin
                                period_reg <= capture_time - last_cap_reg;
                            end
                            last_cap_reg <= capture_time;
                        end
                        else
                        begin
                            pulse_cnt_reg <= pulse_cnt_reg - 8'd1;
                        end
                    end
                    mspt_pkg::CMD_TICK:
                    begin
                        turn_seen_reg <= turn_cnt_reg;
                        if (measure)
                        begin
                            stall_cnt_reg <= '0;
                        end
                        else if (pump_on)
                        begin
                            if (stall_fire)
                            begin
                                stall_cnt_reg <= '0;
                            end
                            else if (cycle_gate_reg && (rate_mode_reg != mspt_pkg::RATE_STOPPED))
                            begin
                                stall_cnt_reg <= stall_cnt_reg + 8'd1;
                            end
                        end
                        // motor start reloads the settle window after this measurement
                        if (pump_on && !motor_run_reg)
                        begin
                            settle_reg <= mspt_pkg::SETTLE_TICKS;
                        end
                        else if (measure)
                        begin
                            settle_reg <= settle_eff - 8'd1;
                        end
                        motor_run_reg <= pump_on;
                    end
                    mspt_pkg::CMD_WIN_END:
                    begin
                        if (rate_mode_reg == mspt_pkg::RATE_DUTY)
                        begin
                            cycle_gate_reg <= 1'b0;
                        end
                    end
                    mspt_pkg::CMD_CYCLE_END:
                    begin
                        if (rate_mode_reg == mspt_pkg::RATE_DUTY)
                        begin
                            cycle_gate_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        cycle_gate_reg <= cycle_gate_reg;
                    end
                endcase
            end

            if (state_reg == mspt_pkg::ST_PREP)
            begin
                integ_sum_reg <= integ_clamped;
                prev_err_reg  <= err;
            end

            if (cfg_write)
            begin
                case (mspt_pkg::reg_idx_t'(cfg_index))
                    mspt_pkg::REG_SETPOINT:   setpoint_reg   <= cfg_data[12:0];
                    mspt_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                    mspt_pkg::REG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                    mspt_pkg::REG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                    mspt_pkg::REG_PPR:        ppr_reg        <= cfg_data[7:0];
                    mspt_pkg::REG_GEAR_RATIO: gear_ratio_reg <= cfg_data[7:0];
                    mspt_pkg::REG_RATE_MODE:
                    begin
                        rate_mode_reg <= cfg_data[1:0];
                        if (cfg_data[1:0] != mspt_pkg::RATE_STOPPED)
                        begin
                            cycle_gate_reg <= 1'b1;
                        end
                    end
                    mspt_pkg::REG_TOT_HOLD:
                    begin
                        tot_hold_reg <= cfg_data[0];
                        if (cfg_data[0])
                        begin
                            total_reg <= '0;
                        end
                    end
                    default:
                    begin
                        tot_hold_reg <= tot_hold_reg;
                    end
                endcase
            end
        end
    end

    // tick working values and result payload
    always_ff @(posedge clk)
    begin
        if (is_tick)
        begin
            pump_reg  <= pump_on;
            alarm_reg <= !measure && pump_on && stall_fire;
            if (!measure)
            begin
                rpm_reg <= '0;
            end
        end
        if ((state_reg == mspt_pkg::ST_DIV) && div_done)
        begin
            rpm_reg <= rpm_sat;
        end
        if (state_reg == mspt_pkg::ST_PREP)
        begin
            d_reg <= diff;
        end
        if (out_load)
        begin
            pwm_out_reg   <= drive ? match : 10'd0;
            rpm_out_reg   <= rpm_reg;
            power_out_reg <= motor_run_reg;
            alarm_out_reg <= alarm_reg;
            total_out_reg <= total_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pwm_match   = pwm_out_reg;
    assign motor_rpm   = rpm_out_reg;
    assign motor_power = power_out_reg;
    assign stall_alarm = alarm_out_reg;
    assign total_turns = total_out_reg;

endmodule

// ===== verif/tb_top.sv =====
// testbench for the motor speed pid controller: predictor, directed and random traffic, checks
`timescale 1ns / 1ps

module tb_top;
    import mspt_pkg::*;

    localparam int          CYCLE_LIMIT   = 800000;
    localparam int          QUIET_CYCLES  = 150;
    localparam int          HOLD_CYCLES   = 1500;
    localparam int          SETTLE_RELOAD = 10;
    localparam int          ALARM_AFTER   = 200;
    localparam int          I_CLAMP       = 5300;
    localparam int unsigned RPM_TOP       = 8191;
    localparam longint      MATCH_TOP     = 599;

    typedef struct {
        logic [9:0]  pwm;
        logic [12:0] rpm;
        logic        power;
        logic        alarm;
        logic [31:0] total;
    } reading_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [31:0] capture_time;
    logic        pump_on;
    logic        out_valid;
    logic        out_stall;
    logic [9:0]  pwm_match;
    logic [12:0] motor_rpm;
    logic        motor_power;
    logic        stall_alarm;
    logic [31:0] total_turns;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // predictor registers
    logic [12:0] sp_cfg   = 13'd0;
    logic [15:0] kp_cfg   = 16'd0;
    logic [15:0] ki_cfg   = 16'd0;
    logic [15:0] kd_cfg   = 16'd0;
    logic [7:0]  ppr_cfg  = 8'd1;
    logic [7:0]  gear_cfg = 8'd1;
    logic [1:0]  mode_cfg = 2'd0;
    logic        hold_cfg = 1'b0;

    // predictor state
    logic [7:0]  pulse_left  = 8'd0;
    logic [15:0] turns       = 16'd0;
    logic [15:0] turns_seen  = 16'd0;
    logic [7:0]  gear_turns  = 8'd0;
    logic [31:0] total       = 32'd0;
    logic [31:0] last_t      = 32'd0;
    logic [31:0] period      = 32'd1;
    logic [7:0]  settle      = 8'd100;
    logic [7:0]  stall_ticks = 8'd0;
    int          integ       = 0;
    int          prev_err    = 0;
    logic        gate        = 1'b1;
    logic        running     = 1'b0;

    reading_t    readings_due[$];
    int          alarms_seen = 0;
    int          mismatches  = 0;
    int          cycle_count = 0;
    logic [31:0] tacho_time  = 32'd0;
    logic        calm;
    logic        hold_req;

    motor_speed_pid_with_tacho u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .capture_time (capture_time),
        .pump_on      (pump_on),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pwm_match    (pwm_match),
        .motor_rpm    (motor_rpm),
        .motor_power  (motor_power),
        .stall_alarm  (stall_alarm),
        .total_turns  (total_turns),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void apply_register(reg_idx_t idx, logic [15:0] value);
        case (idx)
            REG_SETPOINT:   sp_cfg = value[12:0];
            REG_PROP_GAIN:  kp_cfg = value;
            REG_INTEG_GAIN: ki_cfg = value;
            REG_DERIV_GAIN: kd_cfg = value;
            REG_PPR:        ppr_cfg = value[7:0];
            REG_GEAR_RATIO: gear_cfg = value[7:0];
            REG_RATE_MODE:
            begin
                mode_cfg = value[1:0];
                if (mode_cfg != RATE_STOPPED)
                    gate = 1'b1;
            end
            default:
            begin
                hold_cfg = value[0];
                if (hold_cfg)
                    total = 32'd0;
            end
        endcase
    endfunction

    function automatic void apply_command(cmd_t cmd, logic [31:0] t, logic pump);
        reading_t    r;
        int unsigned rpm;
        int          e;
        int          d;
        longint      s;
        longint      n;
        longint      q;
        longint      sp_l;
        longint      kp_l;
        longint      ki_l;
        longint      kd_l;
        logic        alarm;
        logic [9:0]  match;
        case (cmd)
            CMD_PULSE:
            begin
                if (pulse_left == 8'd0)
                begin
                    // ppr of zero reloads 255 through the 8-bit wrap
                    pulse_left = ppr_cfg - 8'd1;
                    turns      = turns + 16'd1;
                    gear_turns = gear_turns + 8'd1;
                    if (gear_turns == gear_cfg)
                    begin
                        if (!hold_cfg)
                            total = total + 32'd1;
                        gear_turns = 8'd0;
                    end
                    if (t > last_t)
                        period = t - last_t;
                    last_t = t;
                end
                else
                begin
                    pulse_left = pulse_left - 8'd1;
                end
            end
            CMD_TICK:
            begin
                rpm   = 0;
                alarm = 1'b0;
                match = 10'd0;
                if (turns != turns_seen)
                begin
                    settle     = 8'(SETTLE_RELOAD);
                    turns_seen = turns;
                end
                if (settle != 8'd0)
                begin
                    settle = settle - 8'd1;
                    rpm    = (period == 32'd0) ? RPM_TOP : 32'd6000000 / period;
                    if (rpm > RPM_TOP)
                        rpm = RPM_TOP;
                    stall_ticks = 8'd0;
                end
                else if (pump)
                begin
                    if (stall_ticks > 8'(ALARM_AFTER) || stall_ticks == 8'hFF)
                    begin
                        alarm       = 1'b1;
                        stall_ticks = 8'd0;
                        alarms_seen++;
                    end
                    else if (gate && mode_cfg != RATE_STOPPED)
                    begin
                        stall_ticks = stall_ticks + 8'd1;
                    end
                end
                sp_l = sp_cfg;
                kp_l = kp_cfg;
                ki_l = ki_cfg;
                kd_l = kd_cfg;
                e    = int'(sp_l) - int'(rpm);
                integ = integ + e;
                if (integ < -I_CLAMP)
                    integ = -I_CLAMP;
                else if (integ > I_CLAMP)
                    integ = I_CLAMP;
                d        = e - prev_err;
                prev_err = e;
                s = kp_l * e + ki_l * integ + kd_l * d;
                n = (sp_l * 256 + s) * 10965 + 64'sd636092 * 256;
                if (n >= 0)
                begin
                    q     = n >>> 24;
                    match = (q > MATCH_TOP) ? 10'(MATCH_TOP) : q[9:0];
                end
                r.pwm = 10'd0;
                if (pump)
                begin
                    if (!running)
                    begin
                        running = 1'b1;
                        settle  = 8'(SETTLE_RELOAD);
                    end
                    if (mode_cfg == RATE_DUTY)
                        r.pwm = gate ? match : 10'd0;
                    else if (mode_cfg != RATE_STOPPED)
                        r.pwm = match;
                end
                else
                begin
                    running = 1'b0;
                end
                r.rpm   = rpm[12:0];
                r.power = running;
                r.alarm = alarm;
                r.total = total;
                readings_due.push_back(r);
            end
            CMD_WIN_END:
            begin
                if (mode_cfg == RATE_DUTY)
                    gate = 1'b0;
            end
            default:
            begin
                if (mode_cfg == RATE_DUTY)
                    gate = 1'b1;
            end
        endcase
    endfunction

    // mostly short idle runs, a few long ones
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 93)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] advance_time(int unsigned step);
        tacho_time = tacho_time + step;
        return tacho_time;
    endfunction

    task automatic send_command(input cmd_t cmd, input logic [31:0] t, input logic pump);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_span();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        capture_time <= t;
        pump_on      <= pump;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        apply_command(cmd, t, pump);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        apply_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // sender pauses until every expected result is in
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (readings_due.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [15:0] sp, input logic [15:0] kp,
                                 input logic [15:0] ki, input logic [15:0] kd,
                                 input logic [15:0] ppr, input logic [15:0] gear,
                                 input logic [15:0] mode, input logic [15:0] hold);
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_PPR, ppr);
        write_reg(REG_GEAR_RATIO, gear);
        write_reg(REG_RATE_MODE, mode);
        write_reg(REG_TOT_HOLD, hold);
    endtask

    task automatic test_after_reset();
        send_command(CMD_TICK, 32'h0000_0000, 1'b0);
        send_command(CMD_TICK, 32'hFFFF_FFFF, 1'b1);
        wait_idle();
    endtask

    task automatic test_directed();
        load_settings(16'd1500, 16'h0180, 16'h0010, 16'h0040, 16'd2, 16'd3, 16'd1, 16'd0);
        send_command(CMD_TICK, 32'h0, 1'b1);
        send_command(CMD_PULSE, 32'd1000, 1'b1);
        send_command(CMD_PULSE, 32'd1400, 1'b0);
        send_command(CMD_PULSE, 32'd1800, 1'b1);
        send_command(CMD_TICK, 32'h0, 1'b1);
        // counted turn with an earlier capture keeps the old period
        send_command(CMD_PULSE, 32'd2000, 1'b1);
        send_command(CMD_PULSE, 32'd900, 1'b1);
        send_command(CMD_TICK, 32'h0, 1'b1);
        send_command(CMD_WIN_END, 32'h0, 1'b0);
        send_command(CMD_TICK, 32'h0, 1'b1);
        send_command(CMD_TICK, 32'h0, 1'b0);
        send_command(CMD_CYCLE_END, 32'h0, 1'b0);
        send_command(CMD_TICK, 32'h0, 1'b1);
        send_command(CMD_PULSE, 32'hFFFF_FFFF, 1'b0);
        send_command(CMD_PULSE, 32'h0000_0000, 1'b1);
        send_command(CMD_TICK, 32'h0, 1'b1);
        wait_idle();
        // mode three runs continuous and ignores window beats
        write_reg(REG_RATE_MODE, 16'd3);
        send_command(CMD_TICK, 32'h0, 1'b1);
        send_command(CMD_WIN_END, 32'h0, 1'b1);
        send_command(CMD_TICK, 32'h0, 1'b1);
        wait_idle();
    endtask

    task automatic test_stall_alarm();
        int goal;
        int count;
        int tail;
        int r;
        load_settings(16'd800, 16'h0100, 16'h0004, 16'h0020, 16'd1, 16'd1, 16'd1, 16'd0);
        goal  = alarms_seen + 1;
        count = 0;
        tail  = 20;
        // no pulses: the speed decays to zero and the idle counter climbs
        while (tail > 0 && count < 700)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_command(CMD_WIN_END, $urandom(), 1'b1);
            else if (r < 25)
                send_command(CMD_CYCLE_END, $urandom(), 1'b0);
            else
                send_command(CMD_TICK, $urandom(), 1'b1);
            count++;
            if (alarms_seen >= goal)
                tail--;
        end
        wait_idle();
    endtask

    task automatic test_turn_wrap();
        int i;
        load_settings(16'd2000, 16'h0080, 16'h0008, 16'h0010, 16'd1, 16'd0, 16'd2, 16'd0);
        // gear ratio zero: the 8-bit turn count wraps before it matches
        for (i = 0; i < 270; i++)
        begin
            send_command(CMD_PULSE, advance_time($urandom_range(20, 400)), $urandom_range(0, 1));
            if (i % 30 == 29)
                send_command(CMD_TICK, $urandom(), 1'b1);
        end
        send_command(CMD_TICK, $urandom(), 1'b1);
        wait_idle();
        write_reg(REG_TOT_HOLD, 16'd1);
        for (i = 0; i < 12; i++)
            send_command(CMD_PULSE, advance_time($urandom_range(20, 400)), 1'b0);
        send_command(CMD_TICK, $urandom(), 1'b1);
        wait_idle();
        write_reg(REG_TOT_HOLD, 16'd0);
        write_reg(REG_PPR, 16'd0);
        for (i = 0; i < 520; i++)
        begin
            send_command(CMD_PULSE, advance_time($urandom_range(2, 60)), $urandom_range(0, 1));
            if (i % 104 == 103)
                send_command(CMD_TICK, $urandom(), 1'b1);
        end
        wait_idle();
        // gear ratio below the running count
        write_reg(REG_GEAR_RATIO, 16'd2);
        write_reg(REG_PPR, 16'd1);
        for (i = 0; i < 10; i++)
            send_command(CMD_PULSE, advance_time($urandom_range(100, 900)), 1'b1);
        send_command(CMD_TICK, $urandom(), 1'b1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        int i;
        hold_req <= 1'b1;
        calm     <= 1'b1;
        for (i = 0; i < 40; i++)
        begin
            if (i % 3 == 2)
                send_command(CMD_TICK, $urandom(), 1'b1);
            else
                send_command(CMD_PULSE, advance_time($urandom_range(200, 2000)), 1'b1);
        end
        calm <= 1'b0;
        wait_idle();
    endtask

    task automatic test_random();
        int          phase;
        int          i;
        int          r;
        int unsigned step_nom;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'd1, 16'd1, 16'd2, 16'd0);
                1: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd3, 16'd255, 16'd1, 16'd0);
                2: load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                                 $urandom_range(0, 1023), $urandom_range(0, 65535),
                                 $urandom_range(1, 6), $urandom_range(1, 8),
                                 $urandom_range(0, 3), $urandom_range(0, 1));
                default: load_settings($urandom_range(500, 6000), $urandom_range(0, 2048),
                                       $urandom_range(0, 256), $urandom_range(0, 2048),
                                       $urandom_range(1, 4), $urandom_range(1, 5),
                                       16'd1, 16'd1);
            endcase
            step_nom = $urandom_range(30, 2500);
            if (phase == 3)
                calm <= 1'b1;
            for (i = 0; i < 115; i++)
            begin
                if (phase == 3 && i == 60)
                    calm <= 1'b0;
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    if ($urandom_range(0, 19) == 0)
                        tacho_time = $urandom();
                    else
                        void'(advance_time(step_nom + $urandom_range(0, step_nom / 8)));
                    send_command(CMD_PULSE, tacho_time, $urandom_range(0, 1));
                end
                else if (r < 85)
                begin
                    send_command(CMD_TICK, $urandom(), $urandom_range(0, 9) != 0);
                end
                else if (r < 93)
                begin
                    send_command(CMD_WIN_END, $urandom(), $urandom_range(0, 1));
                end
                else
                begin
                    send_command(CMD_CYCLE_END, $urandom(), $urandom_range(0, 1));
                end
            end
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        command      <= CMD_PULSE;
        capture_time <= 32'd0;
        pump_on      <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_SETPOINT;
        cfg_data     <= 16'd0;
        calm         <= 1'b0;
        hold_req     <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_directed();
        test_stall_alarm();
        test_turn_wrap();
        test_backpressure();
        test_random();
        wait_idle();
        if (mismatches == 0 && readings_due.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // receiver pacing: random stall runs, calm runs, and one long hold on request
    initial
    begin : rx_pacing
        int run;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req  <= 1'b0;
                out_stall <= 1'b1;
                run = HOLD_CYCLES;
            end
            else if (calm || $urandom_range(0, 1) == 0)
            begin
                out_stall <= 1'b0;
                run = $urandom_range(1, 10);
            end
            else
            begin
                out_stall <= 1'b1;
                run = idle_span();
            end
            repeat (run) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (readings_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: pwm %0d rpm %0d power %0b alarm %0b total %0d",
                             pwm_match, motor_rpm, motor_power, stall_alarm, total_turns);
            end
            else
            begin
                want = readings_due.pop_front();
                if (want.pwm !== pwm_match || want.rpm !== motor_rpm ||
                    want.power !== motor_power || want.alarm !== stall_alarm ||
                    want.total !== total_turns)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: exp pwm %0d rpm %0d pwr %0b alm %0b tot %0d, got pwm %0d rpm %0d pwr %0b alm %0b tot %0d",
                                 $realtime, want.pwm, want.rpm, want.power, want.alarm, want.total,
                                 pwm_match, motor_rpm, motor_power, stall_alarm, total_turns);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
rtl/core/mspt_pkg.sv
rtl/core/mspt_div.sv
rtl/core/mspt_mac.sv
rtl/core/motor_speed_pid_with_tacho.sv
verif/tb_top.sv
